>>> rtl/assert_macros.svh
// Assertion helpers used by the checker file.
// Every macro samples on clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define CSQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csq assertion failed");

// Next-cycle implication: whenever ante holds, cons must hold in the following cycle.
`define CSQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csq assertion failed");

`endif

>>> rtl/csq_pkg.sv
package csq_pkg;

  // Event codes carried on the input tuser.
  localparam logic [1:0] FUNC_ADD     = 2'd0;
  localparam logic [1:0] FUNC_CHECK   = 2'd1;
  localparam logic [1:0] FUNC_BACKOFF = 2'd2;
  localparam logic [1:0] FUNC_CYCLE   = 2'd3;

  // Timer request codes in a result beat.
  localparam logic [1:0] TMR_NONE    = 2'd0;
  localparam logic [1:0] TMR_CHECK   = 2'd1;
  localparam logic [1:0] TMR_CYCLE   = 2'd2;
  localparam logic [1:0] TMR_BACKOFF = 2'd3;

  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_USER_W = 2;

  // One stored command.
  typedef struct packed {
    logic [7:0]  status;
    logic [7:0]  relay;
    logic [31:0] addr;
  } slot_entry_t;

endpackage

>>> rtl/command_slot_queue_with_retry.sv
// Command slot queue with acknowledge and retry. Relay commands (device address, relay
// index, relay status) are parked in a table of SLOTS entries kept in a single-port-write,
// registered-read RAM; a row of occupancy flip-flops marks which slots hold a command with a
// nonzero address. One input beat is one event: add a command, a check result, a backoff
// expiry or a cycle expiry; each event yields exactly one result beat. The block works on
// one event at a time: the accept cycle, a scan of the occupancy flags at one slot per cycle
// for an add, a second scan of the same kind for a dispatch, the RAM read of the dispatched
// entry and the hand-off of the result to the output register. A backoff expiry or a missed
// acknowledge with retries left goes straight from the accept cycle to the hand-off. The
// hand-off cycle stretches for as long as the output register still holds an earlier beat
// that out_tready has not taken. The output register lets a finished result wait for
// out_tready while the next event is accepted. The retry_mode register is written over the
// cfg port and should only change while the block is idle; it resets to 1 (wait for an
// acknowledge and retry).
module command_slot_queue_with_retry #(
  parameter int SLOTS       = 8,
  parameter int MAX_RETRIES = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata from bit 0: dev_address[31:0], relay_index[39:32], relay_state[47:40],
  // acked[48], zero fill up to bit 55.
  input  logic [csq_pkg::IN_DATA_W-1:0]     in_tdata,
  // tuser from bit 0: func[1:0].
  input  logic [csq_pkg::IN_USER_W-1:0]     in_tuser,
  // Result channel.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata from bit 0: slot_id[2:0], send_address[34:3], send_relay[42:35],
  // send_state[50:43], timer_request[52:51], zero fill up to bit 55.
  output logic [csq_pkg::OUT_DATA_W-1:0]    out_tdata,
  // tuser from bit 0: table_full[0], send_valid[1].
  output logic [csq_pkg::OUT_USER_W-1:0]    out_tuser,
  // Configuration channel: retry_mode.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_data
);

  import csq_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RW = (MAX_RETRIES > 0) ? $clog2(MAX_RETRIES + 1) : 1;
  localparam int EW = $bits(slot_entry_t);

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN_E = 3'd1;  // looking for the lowest empty slot
  localparam logic [2:0] S_SCAN_O = 3'd2;  // looking for the lowest occupied slot
  localparam logic [2:0] S_LOAD   = 3'd3;  // RAM data of the dispatched slot is ready
  localparam logic [2:0] S_DONE   = 3'd4;  // result waits for the output register

  logic [2:0]              state_r, state_nxt;
  logic [IW-1:0]           idx_r, idx_nxt;
  logic [SLOTS-1:0]        occ_r, occ_nxt;
  logic                    idle_r, idle_nxt;
  logic                    retry_mode_r, retry_mode_nxt;
  logic [RW-1:0]           retry_r, retry_nxt;
  slot_entry_t             cur_r, cur_nxt;

  // Latched command of the event.
  slot_entry_t             cmd_r, cmd_nxt;

  // Result under construction.
  logic [2:0]              res_slot_r, res_slot_nxt;
  logic                    res_full_r, res_full_nxt;
  logic                    res_send_r, res_send_nxt;
  slot_entry_t             res_cmd_r, res_cmd_nxt;
  logic [1:0]              res_tmr_r, res_tmr_nxt;

  // Output register.
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]   out_data_r, out_data_nxt;
  logic [OUT_USER_W-1:0]   out_user_r, out_user_nxt;

  // RAM port signals.
  logic                    ram_we;
  logic                    ram_re;
  slot_entry_t             ram_rdata;

  logic                    in_acc;
  logic                    idx_last;
  logic [1:0]              send_tmr;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign idx_last  = (idx_r == IW'(SLOTS - 1));
  assign send_tmr  = retry_mode_r ? TMR_CHECK : TMR_CYCLE;
  assign cfg_ready = 1'b1;

  csq_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (cmd_r),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    occ_nxt        = occ_r;
    idle_nxt       = idle_r;
    retry_mode_nxt = retry_mode_r;
    retry_nxt      = retry_r;
    cur_nxt        = cur_r;
    cmd_nxt        = cmd_r;
    res_slot_nxt   = res_slot_r;
    res_full_nxt   = res_full_r;
    res_send_nxt   = res_send_r;
    res_cmd_nxt    = res_cmd_r;
    res_tmr_nxt    = res_tmr_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;

    if (cfg_valid) begin
      retry_mode_nxt = cfg_data;
    end

    // The consumer took the waiting result beat.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt.addr   = in_tdata[31:0];
          cmd_nxt.relay  = in_tdata[39:32];
          cmd_nxt.status = in_tdata[47:40];
          idx_nxt        = '0;
          res_slot_nxt   = '0;
          res_full_nxt   = 1'b0;
          res_send_nxt   = 1'b0;
          res_cmd_nxt    = '0;
          res_tmr_nxt    = TMR_NONE;
          unique case (in_tuser[1:0])
            FUNC_ADD: begin
              state_nxt = S_SCAN_E;
            end
            FUNC_CHECK: begin
              if (in_tdata[48]) begin
                // Acknowledged; the retry count is deliberately left alone.
                idle_nxt  = 1'b1;
                state_nxt = S_SCAN_O;
              end else if (retry_r < RW'(MAX_RETRIES)) begin
                res_tmr_nxt = TMR_BACKOFF;
                retry_nxt   = retry_r + RW'(1);
                state_nxt   = S_DONE;
              end else begin
                // Out of retries: give up on this command and move on.
                idle_nxt  = 1'b1;
                retry_nxt = '0;
                state_nxt = S_SCAN_O;
              end
            end
            FUNC_BACKOFF: begin
              res_send_nxt = 1'b1;
              res_cmd_nxt  = cur_r;
              res_tmr_nxt  = send_tmr;
              state_nxt    = S_DONE;
            end
            FUNC_CYCLE: begin
              idle_nxt  = 1'b1;
              state_nxt = S_SCAN_O;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN_E: begin
        if (!occ_r[idx_r]) begin
          ram_we         = 1'b1;
          occ_nxt[idx_r] = (cmd_r.addr != '0);
          res_slot_nxt   = 3'(idx_r);
          idx_nxt        = '0;
          state_nxt      = idle_r ? S_SCAN_O : S_DONE;
        end else if (idx_last) begin
          res_full_nxt = 1'b1;
          idx_nxt      = '0;
          state_nxt    = idle_r ? S_SCAN_O : S_DONE;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end

      S_SCAN_O: begin
        if (occ_r[idx_r]) begin
          ram_re         = 1'b1;
          occ_nxt[idx_r] = 1'b0;
          idle_nxt       = 1'b0;
          state_nxt      = S_LOAD;
        end else if (idx_last) begin
          // Empty table: nothing to send, idle flag unchanged.
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end

      S_LOAD: begin
        cur_nxt      = ram_rdata;
        res_send_nxt = 1'b1;
        res_cmd_nxt  = ram_rdata;
        res_tmr_nxt  = send_tmr;
        state_nxt    = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'b000, res_tmr_r, res_cmd_r.status, res_cmd_r.relay,
                           res_cmd_r.addr, res_slot_r};
          out_user_nxt  = {res_send_r, res_full_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= '0;
      occ_r        <= '0;
      idle_r       <= 1'b1;
      retry_mode_r <= 1'b1;
      retry_r      <= '0;
      cur_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      occ_r        <= occ_nxt;
      idle_r       <= idle_nxt;
      retry_mode_r <= retry_mode_nxt;
      retry_r      <= retry_nxt;
      cur_r        <= cur_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    res_slot_r <= res_slot_nxt;
    res_full_r <= res_full_nxt;
    res_send_r <= res_send_nxt;
    res_cmd_r  <= res_cmd_nxt;
    res_tmr_r  <= res_tmr_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

>>> rtl/csq_ram.sv
module csq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/csq_checker.sv
`include "assert_macros.svh"

module csq_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [csq_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [csq_pkg::OUT_USER_W-1:0] out_tuser
);

  import csq_pkg::*;

  // A stalled result beat holds its payload.
  `CSQ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, $stable(out_tdata))

  // Without a send, the send fields are zero and no check or cycle timer is asked for.
  `CSQ_ASSERT_IMP(a_nosend_zero, out_tvalid && !out_tuser[1], (out_tdata[50:3] == '0) && (out_tdata[52:51] != TMR_CHECK) && (out_tdata[52:51] != TMR_CYCLE))

  // A send always comes with a check or a cycle timer request.
  `CSQ_ASSERT_IMP(a_send_tmr, out_tvalid && out_tuser[1], (out_tdata[52:51] == TMR_CHECK) || (out_tdata[52:51] == TMR_CYCLE))

  // A full table reports slot zero.
  `CSQ_ASSERT_IMP(a_full_slot, out_tvalid && out_tuser[0], out_tdata[2:0] == 3'd0)

  // One event at a time: the input side closes right after a beat is taken.
  `CSQ_ASSERT_NEXT(a_one_event, in_tvalid && in_tready, !in_tready)

endmodule

bind command_slot_queue_with_retry csq_checker u_csq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
